[design/bwa_pkg.sv]
// Shared types and constants of the BAR window allocator.
`timescale 1ns / 1ps
`default_nettype none

package bwa_pkg;

  localparam int WINDOWS_DEF = 4;
  localparam int SLOT_W      = 2;
  localparam int ADDR_W      = 64;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef enum logic {
    ST_DONE    = 1'b0,
    ST_NOSPACE = 1'b1
  } status_t;

  // Item travelling along the row of window cells
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic              kind;
    logic [ADDR_W-1:0] cpu_base;
    logic [ADDR_W-1:0] bus_base;
    logic [ADDR_W-1:0] length;    // window length on load, request length on allocate
    logic              found;
    logic [ADDR_W-1:0] bus_addr;
    logic [ADDR_W-1:0] host_addr;
  } tok_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] bus_addr;
    logic [ADDR_W-1:0] host_addr;
  } res_t;

endpackage

`default_nettype wire

[design/bwa_if.sv]
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
`default_nettype none

interface bwa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [bwa_pkg::SLOT_W-1:0] win_slot;
  logic                      win_kind;
  logic [bwa_pkg::ADDR_W-1:0] win_cpu_base;
  logic [bwa_pkg::ADDR_W-1:0] win_bus_base;
  logic [bwa_pkg::ADDR_W-1:0] win_length;
  logic                      req_kind;
  logic [bwa_pkg::ADDR_W-1:0] req_length;

  modport source (
    output valid, op, win_slot, win_kind, win_cpu_base, win_bus_base, win_length,
           req_kind, req_length,
    input  ready
  );
  modport sink (
    input  valid, op, win_slot, win_kind, win_cpu_base, win_bus_base, win_length,
           req_kind, req_length,
    output ready
  );
endinterface

interface bwa_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [bwa_pkg::ADDR_W-1:0] bus_addr;
  logic [bwa_pkg::ADDR_W-1:0] host_addr;

  modport source (output valid, status, bus_addr, host_addr, input ready);
  modport sink (input valid, status, bus_addr, host_addr, output ready);
endinterface

`default_nettype wire

[design/bwa_cell.sv]
// One window cell: holds a window slot and tries an allocation over two stages.
`timescale 1ns / 1ps
`default_nettype none

module bwa_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bwa_pkg::tok_t tok_i,
  output bwa_pkg::tok_t      tok_o
);

  localparam int  AW    = bwa_pkg::ADDR_W;
  localparam bit  REACH = (IDX < (1 << bwa_pkg::SLOT_W));

  // window state
  logic          valid_r;
  logic          kind_r;
  logic [AW-1:0] cpu_r;
  logic [AW-1:0] bus_r;
  logic [AW-1:0] len_r;
  logic [AW-1:0] off_r;

  // stage registers
  bwa_pkg::tok_t tok1_r;
  bwa_pkg::tok_t tok2_r;
  logic [AW-1:0] rnd_r;
  logic          ovf_r;
  logic          elig_r;

  logic [AW-1:0] lm1;
  logic [AW:0]   sum;
  logic [AW-1:0] rnd_nxt;
  logic          elig_nxt;
  logic          load_hit;
  logic [AW:0]   ext;
  logic          fit;
  bwa_pkg::tok_t tok2_nxt;

  // stage 1: round the offset up to the request alignment
  always_comb begin
    lm1      = tok_i.length - AW'(1);
    sum      = {1'b0, off_r} + {1'b0, lm1};
    rnd_nxt  = sum[AW-1:0] & ~lm1;
    elig_nxt = (tok_i.op == bwa_pkg::OP_ALLOC) && !tok_i.found && valid_r &&
               (kind_r == tok_i.kind) && (tok_i.length != '0);
    load_hit = tok_i.valid && (tok_i.op == bwa_pkg::OP_LOAD) && REACH &&
               (tok_i.slot == bwa_pkg::SLOT_W'(IDX));
  end

  // stage 2: end of region against window size, carry means no fit
  always_comb begin
    ext      = {1'b0, rnd_r} + {1'b0, tok1_r.length};
    fit      = tok1_r.valid && elig_r && !ovf_r && !ext[AW] && (ext[AW-1:0] <= len_r);
    tok2_nxt = tok1_r;
    if (fit) begin
      tok2_nxt.found     = 1'b1;
      tok2_nxt.bus_addr  = bus_r + rnd_r;
      tok2_nxt.host_addr = cpu_r + rnd_r;
    end
  end

  // window state: load writes the slot, a fit bumps the offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_hit) begin
      valid_r <= 1'b1;
      kind_r  <= tok_i.kind;
      cpu_r   <= tok_i.cpu_base;
      bus_r   <= tok_i.bus_base;
      len_r   <= tok_i.length;
      off_r   <= '0;
    end else if (fit) begin
      off_r   <= ext[AW-1:0];
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r.valid <= 1'b0;
      tok2_r.valid <= 1'b0;
    end else begin
      tok1_r <= tok_i;
      tok2_r <= tok2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r  <= rnd_nxt;
    ovf_r  <= sum[AW];
    elig_r <= elig_nxt;
  end

  assign tok_o = tok2_r;

endmodule

`default_nettype wire

[design/bar_window_allocator.sv]
// Top level of the BAR window allocator: a row of window cells and a result buffer.
`timescale 1ns / 1ps
`default_nettype none

// A load item writes window slot win_slot (slots at or beyond WINDOWS are ignored) and
// answers status 0; an allocate item tries valid windows of req_kind from slot 0 upward,
// aligns the window's offset to req_length and takes the first window that still fits,
// answering the bus and host addresses or status 1 with zero addresses. Every item walks
// the whole row of window cells, two register stages per cell, to the result register. One
// item is in the row at a time; the input opens again as its result is registered in the
// output register, so a new item is not accepted before the last one has left the row. A
// finished result may wait in the output register while the next item is accepted; if the
// output is still full when that item finishes, its result waits in a spare register,
// which holds the input off until the output drains.

module bar_window_allocator #(
  parameter int WINDOWS = bwa_pkg::WINDOWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bwa_in_if.sink    in_ch,
  bwa_out_if.source out_ch
);

  bwa_pkg::tok_t      chain [WINDOWS+1];
  bwa_pkg::tok_t      tok_in;
  logic [WINDOWS:0]   chain_vld;

  logic               inflight_r, inflight_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  bwa_pkg::res_t      out_res_r, out_res_nxt;
  bwa_pkg::res_t      skid_res_r, skid_res_nxt;
  bwa_pkg::res_t      done_res;
  logic               accept;
  logic               take;
  logic               done;

  assign in_ch.ready = !inflight_r && !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = out_ch.valid && out_ch.ready;

  // item entering the row
  always_comb begin
    tok_in.valid     = accept;
    tok_in.op        = bwa_pkg::op_t'(in_ch.op);
    tok_in.slot      = in_ch.win_slot;
    tok_in.kind      = (in_ch.op == bwa_pkg::OP_LOAD) ? in_ch.win_kind : in_ch.req_kind;
    tok_in.cpu_base  = in_ch.win_cpu_base;
    tok_in.bus_base  = in_ch.win_bus_base;
    tok_in.length    = (in_ch.op == bwa_pkg::OP_LOAD) ? in_ch.win_length
                                                      : in_ch.req_length;
    tok_in.found     = 1'b0;
    tok_in.bus_addr  = '0;
    tok_in.host_addr = '0;
  end

  assign chain[0] = tok_in;

  // row of window cells
  for (genvar g = 0; g < WINDOWS; g++) begin : g_cell
    bwa_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= WINDOWS; g++) begin : g_vld
    assign chain_vld[g] = chain[g].valid;
  end

  // result leaving the row
  assign done = chain[WINDOWS].valid;
  always_comb begin
    done_res.status    = (chain[WINDOWS].op == bwa_pkg::OP_ALLOC && !chain[WINDOWS].found)
                         ? bwa_pkg::ST_NOSPACE : bwa_pkg::ST_DONE;
    done_res.bus_addr  = chain[WINDOWS].bus_addr;
    done_res.host_addr = chain[WINDOWS].host_addr;
  end

  // output register with a spare behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    inflight_nxt   = inflight_r;
    if (take) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (done) begin
      inflight_nxt = 1'b0;
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = done_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = done_res;
      end
    end
    if (accept) begin
      inflight_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      inflight_r   <= inflight_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.bus_addr  = out_res_r.bus_addr;
  assign out_ch.host_addr = out_res_r.host_addr;

`ifndef SYNTHESIS
  // never more than one item in the row
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one item in the cell row");

  // an item leaving the row was accounted as in flight
  a_done_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> inflight_r)
    else $error("result without an item in flight");

  // the spare register is used only behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("spare result held while output register empty");

  // a finished item never finds both result registers full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !skid_valid_r)
    else $error("result arrived with no register free");
`endif

endmodule

`default_nettype wire
